// ===== sv/vht_pkg.sv =====
`timescale 1ns / 1ps

package vht_pkg;

  localparam int unsigned COORD_FRAC     = 16;
  localparam int unsigned COEF_FRAC      = 8;
  localparam int unsigned LANE_WIDTH     = 16;
  localparam int unsigned ROW_WIDTH      = 64;
  localparam int unsigned NUM_ROWS       = 4;
  localparam int unsigned CFG_ADDR_WIDTH = 3;
  localparam int unsigned TUSER_WIDTH    = 2;

  localparam logic [CFG_ADDR_WIDTH-1:0] CFG_MODE = 3'd0;
  localparam logic [CFG_ADDR_WIDTH-1:0] CFG_ROW0 = 3'd1;
  localparam logic [CFG_ADDR_WIDTH-1:0] CFG_ROW1 = 3'd2;
  localparam logic [CFG_ADDR_WIDTH-1:0] CFG_ROW2 = 3'd3;
  localparam logic [CFG_ADDR_WIDTH-1:0] CFG_ROW3 = 3'd4;

  // 1.0 in Q8.8, placed on the diagonal at reset
  localparam logic [ROW_WIDTH-1:0] DIAG_ONE = 64'h0000_0000_0000_0100;

  typedef enum logic {
    MODE_LINEAR     = 1'b0,
    MODE_PROJECTIVE = 1'b1
  } mode_e;

  typedef struct packed {
    mode_e                                mode;
    logic [NUM_ROWS-1:0][ROW_WIDTH-1:0]   rows;
  } cfg_t;

endpackage

// ===== sv/vht_front.sv =====
`timescale 1ns / 1ps

module vht_front #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  vht_pkg::cfg_t            cfg_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [3*COORD_WIDTH-1:0] in_coords_i,
  output logic                     push_valid_o,
  input  logic                     push_ready_i,
  output logic [3*COORD_WIDTH:0]   push_data_o
);

  logic                     hold_valid_q;
  logic [3*COORD_WIDTH:0]   hold_data_q;

  assign in_ready_o   = !hold_valid_q || push_ready_i;
  assign push_valid_o = hold_valid_q;
  assign push_data_o  = hold_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      hold_valid_q <= in_valid_i;
    end
  end

  // tag each request with the mode it is to be processed in
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      hold_data_q <= {cfg_i.mode == vht_pkg::MODE_PROJECTIVE, in_coords_i};
    end
  end

endmodule

// ===== sv/vht_queue.sv =====
`timescale 1ns / 1ps

module vht_queue #(
  parameter int unsigned WIDTH = 97,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             push, pop;

  assign push_ready_o = count_q != CntW'(DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + CntW'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== sv/vht_back.sv =====
`timescale 1ns / 1ps

module vht_back #(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned COEF_WIDTH  = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  vht_pkg::cfg_t          cfg_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [3*COORD_WIDTH:0] in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [COORD_WIDTH-1:0] out_x_o,
  output logic [COORD_WIDTH-1:0] out_y_o,
  output logic [COORD_WIDTH-1:0] out_z_o,
  output logic                   out_sat_o,
  output logic                   out_wzero_o
);

  localparam int unsigned CW   = COORD_WIDTH;
  localparam int unsigned CF   = COEF_WIDTH;
  localparam int unsigned PW   = CW + CF;
  localparam int unsigned DW   = CW + CF + 2;
  localparam int unsigned RW   = DW + vht_pkg::COORD_FRAC;
  localparam int unsigned CMPW = DW + CW + 1;
  localparam int unsigned NST  = CW + 2;
  localparam int unsigned LW   = vht_pkg::LANE_WIDTH;

  typedef struct packed {
    logic [RW-1:0] rem;
    logic [CW-1:0] quo;
    logic          big;
    logic          nneg;
  } lane_t;

  typedef struct packed {
    logic               proj;
    logic               wneg;
    logic               wzero;
    logic [DW-1:0]      wmag;
    lane_t [2:0]        lane;
  } stage_t;

  logic stall, adv;

  assign stall      = out_valid_o && !out_ready_i;
  assign adv        = !stall;
  assign in_ready_o = adv;

  // stage A: products
  logic signed [CW-1:0] crd [3];
  logic signed [CF-1:0] cf  [3][4];
  logic                 a_valid_q;
  logic                 a_proj_q;
  logic signed [PW-1:0] a_prod_q [4][3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      crd[r] = in_data_i[r*CW +: CW];
      for (int c = 0; c < 4; c++) begin
        cf[r][c] = cfg_i.rows[r][c*LW +: CF];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_proj_q <= in_data_i[3*CW];
      for (int c = 0; c < 4; c++) begin
        for (int r = 0; r < 3; r++) begin
          a_prod_q[c][r] <= PW'(crd[r]) * PW'(cf[r][c]);
        end
      end
    end
  end

  // stage B: column sums, translation and w term aligned to 24 fraction bits
  logic signed [CF-1:0] trans [4];
  logic                 b_valid_q;
  logic                 b_proj_q;
  logic signed [DW-1:0] b_sum_q [4];

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      trans[c] = cfg_i.rows[3][c*LW +: CF];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_proj_q <= a_proj_q;
      for (int c = 0; c < 4; c++) begin
        b_sum_q[c] <= DW'(a_prod_q[c][0]) + DW'(a_prod_q[c][1]) + DW'(a_prod_q[c][2])
                    + (a_proj_q ? (DW'(trans[c]) <<< vht_pkg::COORD_FRAC) : DW'(0));
      end
    end
  end

  // stage C: magnitudes, w selection, linear result
  logic [DW-1:0] nmag     [4];
  logic [DW-1:0] lin_full [3];
  logic          w_is_zero;
  stage_t        ch_q [NST];
  stage_t        ch_d [NST];
  logic [NST-1:0] ch_valid_q;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      nmag[c] = b_sum_q[c][DW-1] ? DW'(-b_sum_q[c]) : DW'(b_sum_q[c]);
    end
    w_is_zero        = b_sum_q[3] == '0;
    ch_d[0].proj     = b_proj_q;
    ch_d[0].wzero    = b_proj_q && w_is_zero;
    ch_d[0].wneg     = !w_is_zero && b_sum_q[3][DW-1];
    ch_d[0].wmag     = w_is_zero ? (DW'(1) << (vht_pkg::COORD_FRAC + vht_pkg::COEF_FRAC))
                                 : nmag[3];
    for (int c = 0; c < 3; c++) begin
      lin_full[c]          = nmag[c] >> vht_pkg::COEF_FRAC;
      ch_d[0].lane[c].rem  = {nmag[c], {vht_pkg::COORD_FRAC{1'b0}}};
      ch_d[0].lane[c].quo  = b_proj_q ? '0 : lin_full[c][CW-1:0];
      ch_d[0].lane[c].big  = !b_proj_q && (|lin_full[c][DW-1:CW]);
      // linear mode keeps its final sign here; projective keeps the numerator sign
      ch_d[0].lane[c].nneg = b_proj_q ? b_sum_q[c][DW-1]
                                      : (b_sum_q[c][DW-1] && lin_full[c] != '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ch_q[0] <= ch_d[0];
    end
  end

  // restoring divider: first step detects overflow, then one quotient bit a step
  for (genvar j = 1; j < NST; j++) begin : g_div
    localparam int unsigned K = CW + 1 - j;

    always_comb begin
      logic [CMPW-1:0] wsh;
      logic [CMPW-1:0] remx;
      logic [CMPW-1:0] diff;
      logic            take;
      ch_d[j] = ch_q[j-1];
      wsh     = CMPW'(ch_q[j-1].wmag) << K;
      for (int c = 0; c < 3; c++) begin
        remx = CMPW'(ch_q[j-1].lane[c].rem);
        diff = remx - wsh;
        take = remx >= wsh;
        if (ch_q[j-1].proj) begin
          if (j == 1) begin
            ch_d[j].lane[c].big = take;
          end else begin
            ch_d[j].lane[c].quo[K % CW] = take;
            ch_d[j].lane[c].rem         = take ? diff[RW-1:0] : ch_q[j-1].lane[c].rem;
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        ch_q[j] <= ch_d[j];
      end
    end
  end

  // output: sign, clamp, flags
  stage_t        last;
  logic [CW-1:0] res [3];
  logic [2:0]    clamp;
  logic          out_valid_q;
  logic [CW-1:0] out_x_q, out_y_q, out_z_q;
  logic          out_sat_q, out_wzero_q;

  assign last = ch_q[NST-1];

  always_comb begin
    logic          neg;
    logic [CW-1:0] limit;
    logic [CW-1:0] qc;
    for (int c = 0; c < 3; c++) begin
      neg = last.proj ? ((last.lane[c].nneg != last.wneg)
                         && (last.lane[c].quo != '0 || last.lane[c].big))
                      : last.lane[c].nneg;
      limit    = (CW'(1) << (CW - 1)) - CW'(!neg);
      clamp[c] = last.lane[c].big || last.lane[c].quo > limit;
      qc       = clamp[c] ? limit : last.lane[c].quo;
      res[c]   = neg ? -qc : qc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      ch_valid_q  <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      a_valid_q   <= in_valid_i;
      b_valid_q   <= a_valid_q;
      ch_valid_q  <= {ch_valid_q[NST-2:0], b_valid_q};
      out_valid_q <= ch_valid_q[NST-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_x_q     <= res[0];
      out_y_q     <= res[1];
      out_z_q     <= res[2];
      out_sat_q   <= |clamp;
      out_wzero_q <= last.wzero;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_x_o     = out_x_q;
  assign out_y_o     = out_y_q;
  assign out_z_o     = out_z_q;
  assign out_sat_o   = out_sat_q;
  assign out_wzero_o = out_wzero_q;

endmodule

// ===== sv/vec3_homogeneous_transform.sv =====
`timescale 1ns / 1ps

// Transforms one signed Q16.16 point per cycle by a 4x4 Q8.8 matrix (p' = p * M). Mode 0 uses
// the 3x3 part and truncates toward zero; mode 1 adds the translation row, forms w from the
// fourth column and divides each coordinate by w (w of zero is taken as 1.0 and flagged).
// Results saturate to the coordinate width, flagged in tuser. Sustained rate is one point per
// clock unless the output is held off by back-pressure. The pipelined restoring divider
// resolves one quotient bit per stage for all three lanes. Linear points take the same path,
// so order is always kept. Configuration must be written only while no request is in flight;
// the block itself does not enforce it.
module vec3_homogeneous_transform #(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned COEF_WIDTH  = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [vht_pkg::CFG_ADDR_WIDTH-1:0]     cfg_addr_i,
  input  logic [vht_pkg::ROW_WIDTH-1:0]          cfg_wdata_i,
  input  logic                                   s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // in_x, in_y, in_z, zero fill
  input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]     s_axis_tdata_i,
  output logic                                   m_axis_tvalid_o,
  input  logic                                   m_axis_tready_i,
  // out_x, out_y, out_z, zero fill
  output logic [((3*COORD_WIDTH+7)/8)*8-1:0]     m_axis_tdata_o,
  // saturated, w_was_zero
  output logic [vht_pkg::TUSER_WIDTH-1:0]        m_axis_tuser_o
);

  localparam int unsigned TDW = ((3*COORD_WIDTH + 7) / 8) * 8;
  localparam int unsigned EW  = 3*COORD_WIDTH + 1;

  vht_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode <= vht_pkg::MODE_LINEAR;
      for (int r = 0; r < vht_pkg::NUM_ROWS; r++) begin
        cfg_q.rows[r] <= vht_pkg::DIAG_ONE << (vht_pkg::LANE_WIDTH * r);
      end
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        vht_pkg::CFG_MODE: cfg_q.mode    <= vht_pkg::mode_e'(cfg_wdata_i[0]);
        vht_pkg::CFG_ROW0: cfg_q.rows[0] <= cfg_wdata_i;
        vht_pkg::CFG_ROW1: cfg_q.rows[1] <= cfg_wdata_i;
        vht_pkg::CFG_ROW2: cfg_q.rows[2] <= cfg_wdata_i;
        vht_pkg::CFG_ROW3: cfg_q.rows[3] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic          push_valid, push_ready;
  logic [EW-1:0] push_data;
  logic          pop_valid, pop_ready;
  logic [EW-1:0] pop_data;
  logic [COORD_WIDTH-1:0] res_x, res_y, res_z;
  logic          res_sat, res_wzero;

  vht_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_coords_i  (s_axis_tdata_i[3*COORD_WIDTH-1:0]),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  vht_queue #(
    .WIDTH(EW),
    .DEPTH(4)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  vht_back #(
    .COORD_WIDTH(COORD_WIDTH),
    .COEF_WIDTH (COEF_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (pop_valid),
    .in_ready_o  (pop_ready),
    .in_data_i   (pop_data),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_x_o     (res_x),
    .out_y_o     (res_y),
    .out_z_o     (res_z),
    .out_sat_o   (res_sat),
    .out_wzero_o (res_wzero)
  );

  assign m_axis_tdata_o = TDW'({res_z, res_y, res_x});
  assign m_axis_tuser_o = {res_wzero, res_sat};

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import vht_pkg::*;

  localparam int unsigned COORD_W     = 32;
  localparam int unsigned DATA_W      = ((3 * COORD_W + 7) / 8) * 8;
  localparam int unsigned LATENCY     = COORD_W + 7;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned RANDOM_POINTS = 1450;

  localparam logic signed [COORD_W-1:0] COORD_HI = 32'sh7fff_ffff;
  localparam logic signed [COORD_W-1:0] COORD_LO = 32'sh8000_0000;
  localparam logic [COORD_W-1:0] ONE_Q16 = 32'h0001_0000;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic               sat;
    logic               wzero;
  } xform_t;

  logic                      clk_i           = 1'b0;
  logic                      rst_ni          = 1'b0;
  logic                      cfg_we_i        = 1'b0;
  logic [CFG_ADDR_WIDTH-1:0] cfg_addr_i      = '0;
  logic [ROW_WIDTH-1:0]      cfg_wdata_i     = '0;
  logic                      s_axis_tvalid_i = 1'b0;
  logic                      s_axis_tready_o;
  logic [DATA_W-1:0]         s_axis_tdata_i  = '0;
  logic                      m_axis_tvalid_o;
  logic                      m_axis_tready_i = 1'b0;
  logic [DATA_W-1:0]         m_axis_tdata_o;
  logic [TUSER_WIDTH-1:0]    m_axis_tuser_o;

  // copy of the register file as the block should hold it
  mode_e          cur_mode = MODE_LINEAR;
  logic [ROW_WIDTH-1:0] cur_rows [NUM_ROWS] =
    '{DIAG_ONE, DIAG_ONE << 16, DIAG_ONE << 32, DIAG_ONE << 48};

  xform_t transformed_q [$];
  int     mismatches   = 0;
  int     quiet_cycles = 0;
  int     hold_left    = 0;
  bit     idle_en      = 1'b1;

  vec3_homogeneous_transform #(
    .COORD_WIDTH(COORD_W),
    .COEF_WIDTH (16)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic longint coef(int row, int col);
    logic signed [LANE_WIDTH-1:0] lane;
    lane = cur_rows[row][LANE_WIDTH*col +: LANE_WIDTH];
    return lane;
  endfunction

  // p' = p * M, Q16.16 points against Q8.8 coefficients
  function automatic xform_t transform_point(input logic signed [COORD_W-1:0] px, py, pz);
    xform_t r;
    longint pt [3];
    longint acc [4];
    logic signed [127:0] w;
    logic signed [127:0] v;
    logic [COORD_W-1:0] coord [3];
    r = '0;
    pt[0] = px;
    pt[1] = py;
    pt[2] = pz;
    for (int c = 0; c < 4; c++) begin
      acc[c] = 0;
      for (int i = 0; i < 3; i++) acc[c] += pt[i] * coef(i, c);
      if (cur_mode == MODE_PROJECTIVE) acc[c] += coef(3, c) <<< COORD_FRAC;
    end
    w = acc[3];
    if (cur_mode == MODE_PROJECTIVE && w == 0) begin
      w = 128'sd1 <<< (COORD_FRAC + COEF_FRAC);
      r.wzero = 1'b1;
    end
    for (int c = 0; c < 3; c++) begin
      if (cur_mode == MODE_LINEAR) begin
        v = acc[c] / (1 << COEF_FRAC);
      end else begin
        v = acc[c];
        v = (v <<< COORD_FRAC) / w;
      end
      if (v > COORD_HI) begin
        coord[c] = COORD_HI;
        r.sat = 1'b1;
      end else if (v < COORD_LO) begin
        coord[c] = COORD_LO;
        r.sat = 1'b1;
      end else begin
        coord[c] = v[COORD_W-1:0];
      end
    end
    r.x = coord[0];
    r.y = coord[1];
    r.z = coord[2];
    return r;
  endfunction

  function automatic void check_field(string name, logic [COORD_W-1:0] want, got);
    if (want !== got) begin
      if (mismatches < 10) $display("mismatch on %s: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin : check_points
    xform_t want;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o)
        transformed_q.push_back(transform_point(s_axis_tdata_i[31:0], s_axis_tdata_i[63:32],
                                                s_axis_tdata_i[95:64]));
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (transformed_q.size() == 0) begin
          if (mismatches < 10) $display("result with none pending: %h", m_axis_tdata_o);
          mismatches++;
        end else begin
          want = transformed_q.pop_front();
          check_field("out_x", want.x, m_axis_tdata_o[31:0]);
          check_field("out_y", want.y, m_axis_tdata_o[63:32]);
          check_field("out_z", want.z, m_axis_tdata_o[95:64]);
          check_field("saturated", 32'(want.sat), 32'(m_axis_tuser_o[0]));
          check_field("w_was_zero", 32'(want.wzero), 32'(m_axis_tuser_o[1]));
        end
      end
    end
  end

  // receiver: random stalls, or a long hold-off when requested
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      m_axis_tready_i <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      m_axis_tready_i <= !(idle_en && $urandom_range(0, 99) < 10);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  task automatic send_point(input logic [COORD_W-1:0] x, y, z);
    if (idle_en && $urandom_range(0, 99) < 10) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {z, y, x};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (transformed_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_WIDTH-1:0] idx,
                           input logic [ROW_WIDTH-1:0] val, input bit last);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    if (last) cfg_we_i <= 1'b0;
    if (idx == CFG_MODE) cur_mode = mode_e'(val[0]);
    else if (idx <= CFG_ROW3) cur_rows[idx - CFG_ROW0] = val;
  endtask

  task automatic program_transform(input mode_e m, input logic [ROW_WIDTH-1:0] r0, r1, r2, r3);
    write_reg(CFG_MODE, 64'(m), 1'b0);
    write_reg(CFG_ROW0, r0, 1'b0);
    write_reg(CFG_ROW1, r1, 1'b0);
    write_reg(CFG_ROW2, r2, 1'b0);
    write_reg(CFG_ROW3, r3, 1'b1);
  endtask

  function automatic logic [LANE_WIDTH-1:0] rand_coef();
    case ($urandom_range(0, 5))
      0, 1: return LANE_WIDTH'($urandom);
      2: return LANE_WIDTH'($urandom_range(0, 512)) - 16'd256;
      3: return $urandom_range(0, 1) ? 16'h0100 : 16'hff00;
      4: return '0;
      default: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
    endcase
  endfunction

  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2: return COORD_W'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
      3: return COORD_W'($signed($urandom) >>> 8);
      default: begin
        case ($urandom_range(0, 4))
          0: return COORD_HI;
          1: return COORD_LO;
          2: return '0;
          3: return '1;
          default: return 32'd1;
        endcase
      end
    endcase
  endfunction

  task automatic test_reset_state();
    send_point(COORD_HI, COORD_LO, '0);
    send_point('1, 32'd1, 32'h1234_5678);
    wait_drained();
    // indexes past the last register must be ignored
    for (int a = CFG_ROW3 + 1; a < 2 ** CFG_ADDR_WIDTH; a++)
      write_reg(a[CFG_ADDR_WIDTH-1:0], '1, a == 2 ** CFG_ADDR_WIDTH - 1);
    send_point(COORD_LO, COORD_HI, '1);
    wait_drained();
  endtask

  task automatic test_linear_corners();
    program_transform(MODE_LINEAR, {4{16'h7fff}}, {4{16'h7fff}}, {4{16'h7fff}}, {4{16'h7fff}});
    send_point(COORD_HI, COORD_HI, COORD_HI);
    send_point(COORD_LO, COORD_LO, COORD_LO);
    wait_drained();
    program_transform(MODE_LINEAR, 64'h8000, 64'h8000 << 16, 64'h8000 << 32, '1);
    send_point(COORD_LO, COORD_HI, 32'd1);
    wait_drained();
    // halves must truncate toward zero; translation row ignored
    program_transform(MODE_LINEAR, 64'h0080, 64'h0080 << 16, 64'h0080 << 32,
                      64'h7fff_1234_8000_00ff);
    send_point('1, 32'd1, 32'hffff_fffd);
    wait_drained();
    program_transform(MODE_LINEAR, '0, '0, '0, '0);
    send_point(32'hdead_beef, COORD_LO, COORD_HI);
    wait_drained();
  endtask

  function automatic logic [ROW_WIDTH-1:0] cur_rows_ident(int row);
    return DIAG_ONE << (LANE_WIDTH * row);
  endfunction

  task automatic test_projective_corners();
    program_transform(MODE_PROJECTIVE, cur_rows_ident(0), cur_rows_ident(1), cur_rows_ident(2),
                      {16'h0100, 16'h0200, 16'hff00, 16'h0080});
    send_point(ONE_Q16, 2 * ONE_Q16, -3 * ONE_Q16);
    send_point(COORD_HI, COORD_LO, '0);
    wait_drained();
    // w of zero: taken as 1.0 and flagged
    program_transform(MODE_PROJECTIVE, cur_rows_ident(0), cur_rows_ident(1), cur_rows_ident(2),
                      '0);
    send_point(ONE_Q16, -ONE_Q16, COORD_HI);
    wait_drained();
    program_transform(MODE_PROJECTIVE, cur_rows_ident(0), cur_rows_ident(1), cur_rows_ident(2),
                      {16'hff00, 48'h0});
    send_point(COORD_LO, COORD_HI, 32'd5);
    wait_drained();
    program_transform(MODE_PROJECTIVE, cur_rows_ident(0), cur_rows_ident(1), cur_rows_ident(2),
                      {16'h0001, 48'h0});
    send_point(32'd1, '1, 32'h100);
    send_point(32'h0100_0000, '0, '0);
    wait_drained();
    // w follows x: non-integer quotients of both signs, and w of zero per point
    program_transform(MODE_PROJECTIVE, {16'h0100, 48'h0100}, cur_rows_ident(1),
                      cur_rows_ident(2), '0);
    send_point(3 * ONE_Q16, ONE_Q16, -ONE_Q16);
    send_point(-2 * ONE_Q16, ONE_Q16, ONE_Q16);
    send_point('0, ONE_Q16, COORD_LO);
    wait_drained();
    program_transform(MODE_PROJECTIVE, cur_rows_ident(0), cur_rows_ident(1), cur_rows_ident(2),
                      {16'h8000, 48'h7fff_0001_ffff});
    send_point(COORD_HI, COORD_LO, 32'h80);
    wait_drained();
  endtask

  // output held off long enough for the pipeline to fill and stall the input
  task automatic test_output_stall();
    program_transform(MODE_PROJECTIVE, cur_rows_ident(0), cur_rows_ident(1), cur_rows_ident(2),
                      {16'h0100, 16'h0040, 16'hfe80, 16'h0300});
    idle_en   = 1'b0;
    hold_left = HOLD_CYCLES;
    repeat (150) send_point(rand_coord(), rand_coord(), rand_coord());
    wait_drained();
    idle_en = 1'b1;
  endtask

  task automatic test_random_phases();
    int sent;
    int phase;
    int n;
    mode_e m;
    logic [ROW_WIDTH-1:0] rows [NUM_ROWS];
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_POINTS) begin
      m = (phase < 4) ? mode_e'(phase % 2) : mode_e'($urandom_range(0, 1));
      for (int r = 0; r < NUM_ROWS; r++)
        for (int c = 0; c < 4; c++) rows[r][LANE_WIDTH*c +: LANE_WIDTH] = rand_coef();
      // constant w for a share of the projective phases
      if (m == MODE_PROJECTIVE && $urandom_range(0, 2) == 0)
        for (int r = 0; r < 3; r++) rows[r][63:48] = '0;
      program_transform(m, rows[0], rows[1], rows[2], rows[3]);
      idle_en = (phase != 2);
      n = $urandom_range(60, 200);
      repeat (n) send_point(rand_coord(), rand_coord(), rand_coord());
      sent += n;
      wait_drained();
      phase++;
    end
    idle_en = 1'b1;
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_linear_corners();
    test_projective_corners();
    test_output_stall();
    test_random_phases();
    wait_drained();
    repeat (LATENCY + 10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
